[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ptok_pkg.sv]
// ----------------------------------------------------------------------------
// ptok_pkg
// Types, character codes and per-byte cleaning and splitting logic.
// ----------------------------------------------------------------------------
package ptok_pkg;

  localparam int DEPTH_BITS     = 8;
  localparam int COUNT_BITS     = 16;
  localparam int TOTAL_BITS     = 16;
  localparam int NUM_SLOTS      = 3;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [COUNT_BITS-1:0] tally_t;

  localparam depth_t DEPTH_MAX = '1;
  localparam tally_t COUNT_MAX = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FOLD_LOWER = 2'd0,
    REG_SPLIT_ON_SEP = 2'd1,
    REG_SEPARATOR = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] SEP_RESET = 8'h09;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic       fold_lower;
    logic       split_on_sep;
    logic [7:0] sep;
  } cfg_t;

  typedef struct packed {
    logic               at_start;
    logic [7:0]         prev;
    depth_t [3:0]       depth;
    logic               in_token;
    tally_t             tally;
  } str_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic       start;
    str_state_t st;
  } step_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  token_start;
    logic                  is_summary;
    logic [TOTAL_BITS-1:0] token_total;
    logic                  last_of_run;
  } result_t;

  typedef struct packed {
    result_t [NUM_SLOTS-1:0] res;
    logic [1:0]              cnt;
  } group_t;

  function automatic str_state_t clean_state();
    str_state_t s;
    s          = '0;
    s.at_start = 1'b1;
    return s;
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c, logic en);
    if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [1:0] bracket_kind(logic [7:0] c);
    case (c)
      CH_LANGLE, CH_RANGLE:   return 2'd1;
      CH_LBRACE, CH_RBRACE:   return 2'd2;
      CH_LSQUARE, CH_RSQUARE: return 2'd3;
      default:                return 2'd0;
    endcase
  endfunction

  function automatic logic is_spaced(logic [7:0] c);
    return c inside {CH_NL, CH_HYPHEN, CH_QUOTE};
  endfunction

  function automatic logic is_mark(logic [7:0] c);
    return c inside {CH_DOT, CH_COMMA, CH_COLON, CH_QMARK, CH_BANG, CH_SEMI};
  endfunction

  function automatic logic is_opener(logic [7:0] c);
    return c inside {CH_LPAREN, CH_LANGLE, CH_LBRACE, CH_LSQUARE};
  endfunction

  function automatic logic is_closer(logic [7:0] c);
    return c inside {CH_RPAREN, CH_RANGLE, CH_RBRACE, CH_RSQUARE};
  endfunction

  function automatic logic [TOTAL_BITS-1:0] sat_total(tally_t t);
    logic [31:0] w;
    w = 32'(t);
    if (w > 32'(TOTAL_BITS'('1))) return '1;
    return w[TOTAL_BITS-1:0];
  endfunction

  // Cleans byte c with lookahead nxt (zero at the end of the string) and
  // splits the cleaned byte into the token stream.
  function automatic step_t ptok_step(str_state_t s, cfg_t cfg,
                                      logic [7:0] c, logic [7:0] nxt);
    step_t      r;
    logic [1:0] k;
    depth_t     d;
    logic       keep;
    logic       use_mark;
    logic [7:0] ch;
    logic [7:0] sep;
    logic       blank;
    logic       is_sep;
    r        = '0;
    r.st     = s;
    k        = bracket_kind(c);
    d        = s.depth[k];
    keep     = 1'b1;
    use_mark = 1'b0;
    ch       = fold(c, cfg.fold_lower);
    if (s.at_start) begin
      if (is_spaced(c) || is_mark(c)) begin
        ch = CH_SPACE;
      end else if (is_opener(c)) begin
        ch = CH_SPACE;
        if (d != DEPTH_MAX) r.st.depth[k] = d + 1'b1;
      end
    end else if (is_spaced(c)) begin
      ch = CH_SPACE;
    end else if (is_mark(c)) begin
      use_mark = 1'b1;
    end else if (is_closer(c)) begin
      if (d != '0) begin
        r.st.depth[k] = d - 1'b1;
        ch            = CH_SPACE;
      end else begin
        use_mark = 1'b1;
      end
    end else if (is_opener(c)) begin
      if (s.prev == CH_SPACE || d != '0) begin
        ch = CH_SPACE;
        if (d != DEPTH_MAX) r.st.depth[k] = d + 1'b1;
      end else begin
        ch = c;
      end
    end
    if (use_mark) begin
      if (nxt == CH_SPACE) ch = CH_SPACE;
      else if (nxt == CH_NUL) keep = 1'b0;
      else ch = c;
    end
    r.st.at_start = 1'b0;
    r.ch          = ch;
    if (keep) begin
      r.st.prev = ch;
      sep       = fold(cfg.sep, cfg.fold_lower);
      blank     = (ch == CH_SPACE) || (ch == CH_TAB);
      is_sep    = (sep != CH_NUL) && (ch == sep);
      if (cfg.split_on_sep) begin
        if (!s.in_token) begin
          if (!(blank || is_sep)) begin
            r.st.in_token = 1'b1;
            r.emit        = 1'b1;
            r.start       = 1'b1;
            if (s.tally != COUNT_MAX) r.st.tally = s.tally + 1'b1;
          end
        end else if (is_sep) begin
          r.st.in_token = 1'b0;
        end else begin
          r.emit = 1'b1;
        end
      end else begin
        if (blank) begin
          r.st.in_token = 1'b0;
        end else begin
          r.emit = 1'b1;
          if (!s.in_token) begin
            r.st.in_token = 1'b1;
            r.start       = 1'b1;
            if (s.tally != COUNT_MAX) r.st.tally = s.tally + 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

[src/ptok_engine.sv]
// ----------------------------------------------------------------------------
// ptok_engine
// String state and the per-item cleaning of the held byte and the new byte.
// ----------------------------------------------------------------------------
module ptok_engine import ptok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] item_byte,
  input  logic       item_has_byte,
  input  logic       item_eos,
  input  cfg_t       cfg,
  output group_t     group
);

  logic [7:0] held_byte;
  logic [7:0] held_byte_next;
  logic       held_valid;
  logic       held_valid_next;
  str_state_t st;
  str_state_t st_next;

  logic       has;
  logic       use_held;
  logic       use_last;
  step_t      step_held;
  step_t      step_last;
  str_state_t st_mid;
  str_state_t st_end;
  result_t [NUM_SLOTS-1:0] cand;
  logic [NUM_SLOTS-1:0]    cand_valid;
  logic [1:0]              n;

  always_comb begin
    has             = item_has_byte && (item_byte != CH_NUL);
    use_held        = has && held_valid;
    step_held       = ptok_step(st, cfg, held_byte, item_byte);
    st_mid          = use_held ? step_held.st : st;
    held_byte_next  = has ? item_byte : held_byte;
    held_valid_next = has || held_valid;
    use_last        = item_eos && held_valid_next;
    step_last       = ptok_step(st_mid, cfg, held_byte_next, CH_NUL);
    st_end          = use_last ? step_last.st : st_mid;
    st_next         = st_mid;
    if (item_eos) begin
      held_byte_next  = CH_NUL;
      held_valid_next = 1'b0;
      st_next         = clean_state();
    end

    cand          = '0;
    cand_valid[0] = use_held && step_held.emit;
    cand[0].out_byte    = step_held.ch;
    cand[0].token_start = step_held.start;
    cand_valid[1] = use_last && step_last.emit;
    cand[1].out_byte    = step_last.ch;
    cand[1].token_start = step_last.start;
    cand_valid[2] = item_eos;
    cand[2].is_summary  = 1'b1;
    cand[2].token_total = sat_total(st_end.tally);

    group = '0;
    n     = 2'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cand_valid[i]) begin
        group.res[n] = cand[i];
        n            = n + 2'd1;
      end
    end
    group.cnt = n;
    if (n != 2'd0) group.res[n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= CH_NUL;
      held_valid <= 1'b0;
      st         <= clean_state();
    end else if (fire) begin
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      st         <= st_next;
    end
  end

endmodule

[src/punct_normalizing_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// punct_normalizing_tokenizer_top
// Streaming punctuation cleaner and tokenizer, one raw byte per input item.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one raw byte per transaction
// with has_byte and end_of_string. Each byte is held until the next byte
// arrives as its lookahead or the string ends, so a byte's token output
// appears with the next byte or end_of_string. The output channel (out_valid,
// out_stall) returns token bytes with token_start, and one summary
// transaction per string with the token count; last_of_run marks the final
// result of each input. An accepted input passes through the input register
// and then the result group register before its first result is shown.
// An input produces up to three results, which leave one per cycle while
// out_stall is low, so the block takes one input per cycle while inputs give
// at most one result each; an input giving more results holds the next input
// until its last result is taken. The result group register sets this limit.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready; a write must be issued only while no transaction is in flight, but
// the block itself does not enforce this. Reset clears the string state and
// both stages. When out_stall is high the shown result holds, and in_stall
// rises once the input register holds a transaction that cannot move on.
// ----------------------------------------------------------------------------
module punct_normalizing_tokenizer_top import ptok_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      has_byte,
  input  logic                      end_of_string,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      token_start,
  output logic                      is_summary,
  output logic [TOTAL_BITS-1:0]     token_total,
  output logic                      last_of_run,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                cfg_data
);

  cfg_t cfg;

  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_has_byte;
  logic       ir_eos;

  result_t [NUM_SLOTS-1:0] grp_res;
  logic [1:0]              grp_cnt;
  logic [1:0]              pos;

  group_t     group;
  logic       out_take;
  logic       grp_free;
  logic       fire;
  logic       in_take;
  result_t    cur;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fold_lower   <= 1'b0;
      cfg.split_on_sep <= 1'b0;
      cfg.sep          <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOLD_LOWER:   cfg.fold_lower   <= cfg_data[0];
        REG_SPLIT_ON_SEP: cfg.split_on_sep <= cfg_data[0];
        REG_SEPARATOR:    cfg.sep          <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign out_valid = (pos < grp_cnt);
  assign out_take  = out_valid && !out_stall;
  assign grp_free  = !out_valid || (out_take && (pos == grp_cnt - 2'd1));
  assign fire      = ir_valid && grp_free;
  assign in_stall  = ir_valid && !fire;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_byte     <= in_byte;
      ir_has_byte <= has_byte;
      ir_eos      <= end_of_string;
    end
  end

  ptok_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item_byte     (ir_byte),
    .item_has_byte (ir_has_byte),
    .item_eos      (ir_eos),
    .cfg           (cfg),
    .group         (group)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_cnt <= 2'd0;
      pos     <= 2'd0;
    end else if (fire) begin
      grp_cnt <= group.cnt;
      pos     <= 2'd0;
    end else if (out_take) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      grp_res <= group.res;
    end
  end

  assign cur         = grp_res[pos];
  assign out_byte    = cur.out_byte;
  assign token_start = cur.token_start;
  assign is_summary  = cur.is_summary;
  assign token_total = cur.token_total;
  assign last_of_run = cur.last_of_run;

endmodule

[src/ptok_checker.sv]
// ----------------------------------------------------------------------------
// ptok_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptok_checker import ptok_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [7:0]            out_byte,
  input logic                  token_start,
  input logic                  is_summary,
  input logic [TOTAL_BITS-1:0] token_total,
  input logic                  last_of_run
);

  logic show_sum;
  logic show_tok;

  assign show_sum = out_valid && is_summary;
  assign show_tok = out_valid && !is_summary;

  `ASSERT_CLK(a_valid_holds, clk, rst, out_valid && out_stall |=> out_valid, "valid dropped")
  `ASSERT_CLK(a_summary_last, clk, rst, show_sum |-> last_of_run, "summary is not last")
  `ASSERT_CLK(a_sum_clean, clk, rst, show_sum |-> out_byte == '0 && !token_start, "summary byte")
  `ASSERT_CLK(a_tok_fields, clk, rst, show_tok |-> token_total == '0 && out_byte != '0, "bad token")
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, $past(rst) && !rst |-> !out_valid, "result after reset")

endmodule

bind punct_normalizing_tokenizer_top ptok_checker u_ptok_checker (.*);

[tb/tb_punct_normalizing_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// tb_punct_normalizing_tokenizer_top
// Self-checking bench for the streaming punctuation cleaner and tokenizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first. Rows that start from reset
// or hit extreme bytes carry their expected tokens. All other rows, and the
// random strings that follow, are checked against a behavioral tokenizer in
// this file. The random strings run under six register settings with
// different sender and receiver idling. One setting also gets a long output
// hold-off and a nested bracket string.
// ----------------------------------------------------------------------------
module tb_punct_normalizing_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptok_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 30;
  localparam int DEEP_OPEN     = 6;

  typedef struct packed {
    logic          is_cfg;
    cfg_reg_t      reg_idx;
    logic [7:0]    ch;
    logic          has;
    logic          eos;
    logic          typed;
    logic [1:0]    n_typed;
    result_t [2:0] typed_res;
  } drive_row_t;

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic [7:0]                in_byte       = '0;
  logic                      has_byte      = 1'b0;
  logic                      end_of_string = 1'b0;
  logic                      out_stall     = 1'b0;
  logic                      cfg_valid     = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
  logic [7:0]                cfg_data      = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      token_start;
  logic                      is_summary;
  logic [TOTAL_BITS-1:0]     token_total;
  logic                      last_of_run;
  logic                      cfg_ready;

  int          send_idle_pct = 28;
  int          recv_idle_pct = 82;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          mismatches    = 0;
  int unsigned cycle_count   = 0;

  // Tokenizer model state and register copies.
  logic       fold_on;
  logic       sep_mode;
  logic [7:0] sep_code;
  logic [7:0] held_ch;
  logic       held_ok;
  logic       fresh;
  logic [7:0] last_clean;
  depth_t     depth [4];
  logic       in_word;
  tally_t     word_count;

  result_t item_tokens [3];
  int      item_n;
  result_t queued_tokens [$];

  drive_row_t dir_rows [$];

  punct_normalizing_tokenizer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .has_byte      (has_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .token_start   (token_start),
    .is_summary    (is_summary),
    .token_total   (token_total),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver either serves a requested hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic result_t tok(logic [7:0] b, logic start, logic summ,
                                  logic [TOTAL_BITS-1:0] total, logic last);
    result_t r;
    r.out_byte    = b;
    r.token_start = start;
    r.is_summary  = summ;
    r.token_total = total;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic drive_row_t in_row(logic [7:0] ch, logic has, logic eos);
    drive_row_t r;
    r     = '0;
    r.ch  = ch;
    r.has = has;
    r.eos = eos;
    return r;
  endfunction

  function automatic drive_row_t cfg_row(cfg_reg_t idx, logic [7:0] data);
    drive_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.ch      = data;
    return r;
  endfunction

  function automatic drive_row_t typed_row(logic [7:0] ch, logic has, logic eos,
                                           logic [1:0] n, result_t r0,
                                           result_t r1, result_t r2);
    drive_row_t r;
    r              = in_row(ch, has, eos);
    r.typed        = 1'b1;
    r.n_typed      = n;
    r.typed_res[0] = r0;
    r.typed_res[1] = r1;
    r.typed_res[2] = r2;
    return r;
  endfunction

  function automatic void add_row(drive_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void queue_result(result_t r);
    queued_tokens = {queued_tokens, r};
  endfunction

  function automatic logic [7:0] letter(int idx, logic lower);
    return CH_UPPER_A + 8'(idx) + (lower ? CASE_OFFSET : CH_NUL);
  endfunction

  function automatic void clear_string();
    held_ch    = '0;
    held_ok    = 1'b0;
    fresh      = 1'b1;
    last_clean = '0;
    for (int i = 0; i < 4; i++) depth[i] = '0;
    in_word    = 1'b0;
    word_count = '0;
  endfunction

  function automatic void apply_cfg(cfg_reg_t idx, logic [7:0] data);
    case (idx)
      REG_FOLD_LOWER:   fold_on  = data[0];
      REG_SPLIT_ON_SEP: sep_mode = data[0];
      REG_SEPARATOR:    sep_code = data;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] case_fold(logic [7:0] c);
    if (fold_on && c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  function automatic int bracket_slot(logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN:   return 0;
      CH_LANGLE, CH_RANGLE:   return 1;
      CH_LBRACE, CH_RBRACE:   return 2;
      CH_LSQUARE, CH_RSQUARE: return 3;
      default:                return -1;
    endcase
  endfunction

  function automatic void deepen(int slot);
    if (depth[slot] != DEPTH_MAX) depth[slot] = depth[slot] + depth_t'(1);
  endfunction

  // Marks turn into a space before a space and vanish at the string end.
  function automatic int after_mark(logic [7:0] c, logic [7:0] nxt);
    if (nxt == CH_SPACE) return int'(CH_SPACE);
    if (nxt == CH_NUL) return -1;
    return int'(c);
  endfunction

  function automatic int clean_char(logic [7:0] c, logic [7:0] nxt);
    int slot;
    slot = bracket_slot(c);
    if (fresh) begin
      case (c)
        CH_NL, CH_HYPHEN, CH_QUOTE, CH_DOT, CH_COMMA, CH_COLON, CH_QMARK,
        CH_BANG, CH_SEMI:
          return int'(CH_SPACE);
        CH_LPAREN, CH_LANGLE, CH_LBRACE, CH_LSQUARE: begin
          deepen(slot);
          return int'(CH_SPACE);
        end
        default: return int'(case_fold(c));
      endcase
    end
    case (c)
      CH_NL, CH_HYPHEN, CH_QUOTE:
        return int'(CH_SPACE);
      CH_DOT, CH_COMMA, CH_COLON, CH_QMARK, CH_BANG, CH_SEMI:
        return after_mark(c, nxt);
      CH_RPAREN, CH_RANGLE, CH_RBRACE, CH_RSQUARE: begin
        if (depth[slot] != '0) begin
          depth[slot] = depth[slot] - depth_t'(1);
          return int'(CH_SPACE);
        end
        return after_mark(c, nxt);
      end
      CH_LPAREN, CH_LANGLE, CH_LBRACE, CH_LSQUARE: begin
        if (last_clean == CH_SPACE || depth[slot] != '0) begin
          deepen(slot);
          return int'(CH_SPACE);
        end
        return int'(c);
      end
      default: return int'(case_fold(c));
    endcase
  endfunction

  function automatic void add_token(logic [7:0] b, logic start);
    item_tokens[item_n] = tok(b, start, 1'b0, '0, 1'b0);
    item_n++;
  endfunction

  function automatic void open_word(logic [7:0] c);
    in_word = 1'b1;
    if (word_count != COUNT_MAX) word_count = word_count + tally_t'(1);
    add_token(c, 1'b1);
  endfunction

  function automatic void split_char(logic [7:0] c);
    logic       blank;
    logic       is_sep;
    logic [7:0] sep;
    blank  = (c == CH_SPACE) || (c == CH_TAB);
    sep    = case_fold(sep_code);
    is_sep = (sep != CH_NUL) && (c == sep);
    if (sep_mode) begin
      if (!in_word) begin
        if (!(blank || is_sep)) open_word(c);
      end else if (is_sep) begin
        in_word = 1'b0;
      end else begin
        add_token(c, 1'b0);
      end
    end else begin
      if (blank) in_word = 1'b0;
      else if (!in_word) open_word(c);
      else add_token(c, 1'b0);
    end
  endfunction

  function automatic void consume(logic [7:0] c, logic [7:0] nxt);
    int r;
    r     = clean_char(c, nxt);
    fresh = 1'b0;
    if (r >= 0) begin
      last_clean = 8'(r);
      split_char(8'(r));
    end
  endfunction

  function automatic void tokenize_item(logic [7:0] ch, logic has_in, logic eos);
    logic has;
    item_n = 0;
    has    = has_in && (ch != CH_NUL);
    if (has) begin
      if (held_ok) consume(held_ch, ch);
      held_ch = ch;
      held_ok = 1'b1;
    end
    if (eos) begin
      if (held_ok) consume(held_ch, CH_NUL);
      item_tokens[item_n] = tok(CH_NUL, 1'b0, 1'b1, word_count, 1'b0);
      item_n++;
      clear_string();
    end
    if (item_n > 0) item_tokens[item_n-1].last_of_run = 1'b1;
  endfunction

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected byte %h start %b summary %b total %0d last %b,",
               $realtime, what, want.out_byte, want.token_start, want.is_summary,
               want.token_total, want.last_of_run);
      $display("    got byte %h start %b summary %b total %0d last %b",
               got.out_byte, got.token_start, got.is_summary, got.token_total,
               got.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = tok(out_byte, token_start, is_summary, token_total, last_of_run);
      if (queued_tokens.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
      end else begin
        want = queued_tokens.pop_front();
        if (got.out_byte !== want.out_byte || got.token_start !== want.token_start ||
            got.is_summary !== want.is_summary ||
            got.token_total !== want.token_total ||
            got.last_of_run !== want.last_of_run) begin
          note_mismatch("token mismatch", want, got);
        end
      end
    end
  end

  task automatic send_row(input drive_row_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= r.ch;
    has_byte      <= r.has;
    end_of_string <= r.eos;
    do @(posedge clk); while (in_stall);
    tokenize_item(r.ch, r.has, r.eos);
    if (r.typed) begin
      for (int i = 0; i < r.n_typed; i++) queue_result(r.typed_res[i]);
    end else begin
      for (int i = 0; i < item_n; i++) queue_result(item_tokens[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (queued_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return letter($urandom_range(0, 25), 1'($urandom_range(0, 1)));
    if (roll < 42) return CH_SPACE;
    if (roll < 46) return CH_TAB;
    if (roll < 58) begin
      case ($urandom_range(0, 5))
        0:       return CH_DOT;
        1:       return CH_COMMA;
        2:       return CH_COLON;
        3:       return CH_QMARK;
        4:       return CH_BANG;
        default: return CH_SEMI;
      endcase
    end
    if (roll < 72) begin
      case ($urandom_range(0, 7))
        0:       return CH_LPAREN;
        1:       return CH_RPAREN;
        2:       return CH_LANGLE;
        3:       return CH_RANGLE;
        4:       return CH_LBRACE;
        5:       return CH_RBRACE;
        6:       return CH_LSQUARE;
        default: return CH_RSQUARE;
      endcase
    end
    if (roll < 78) begin
      case ($urandom_range(0, 2))
        0:       return CH_NL;
        1:       return CH_HYPHEN;
        default: return CH_QUOTE;
      endcase
    end
    if (roll < 84) return sep_code;
    return 8'($urandom_range(0, 255));
  endfunction

  // Strings of random length; a few bare markers are mixed in, and those that do not end a string are ignored.
  task automatic random_strings(int target);
    int         done;
    int         len;
    logic [7:0] ch;
    logic       has;
    logic       eos;
    done = 0;
    while (done < target) begin
      len = $urandom_range(1, 14);
      for (int k = 0; k < len; k++) begin
        eos = (k == len - 1);
        ch  = pick_char();
        has = 1'b1;
        if (eos && $urandom_range(0, 4) == 0) has = 1'b0;
        else if (!eos && $urandom_range(0, 19) == 0) has = 1'b0;
        send_row(in_row(ch, has, eos));
        if (eos || (has && ch != CH_NUL)) done++;
      end
    end
  endtask

  // Opens the square depth several levels, then closes it one past zero.
  task automatic nest_deep();
    repeat (DEEP_OPEN) send_row(in_row(CH_LSQUARE, 1'b1, 1'b0));
    repeat (DEEP_OPEN + 1) send_row(in_row(CH_RSQUARE, 1'b1, 1'b0));
    send_row(in_row(letter(0, 1'b1), 1'b1, 1'b0));
    send_row(in_row(CH_NUL, 1'b0, 1'b1));
  endtask

  task automatic run_phase(logic f, logic s, logic [7:0] sep, int s_pct, int r_pct,
                           logic press);
    settle();
    write_cfg(REG_FOLD_LOWER, 8'(f));
    write_cfg(REG_SPLIT_ON_SEP, 8'(s));
    write_cfg(REG_SEPARATOR, sep);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    if (press) hold_requests <= hold_requests + 1;
    random_strings(PHASE_ITEMS);
  endtask

  initial begin
    fold_on  = 1'b0;
    sep_mode = 1'b0;
    sep_code = SEP_RESET;
    clear_string();

    add_row(typed_row(CH_UPPER_A, 1'b1, 1'b1, 2'd2,
                      tok(CH_UPPER_A, 1'b1, 1'b0, '0, 1'b0),
                      tok(CH_NUL, 1'b0, 1'b1, 16'd1, 1'b1), '0));
    add_row(typed_row(CH_NUL, 1'b0, 1'b1, 2'd1,
                      tok(CH_NUL, 1'b0, 1'b1, '0, 1'b1), '0, '0));
    add_row(typed_row(8'hFF, 1'b1, 1'b0, 2'd0, '0, '0, '0));
    add_row(typed_row(8'hA5, 1'b0, 1'b0, 2'd0, '0, '0, '0));
    add_row(typed_row(CH_NUL, 1'b1, 1'b0, 2'd0, '0, '0, '0));
    add_row(typed_row(8'h01, 1'b1, 1'b1, 2'd3,
                      tok(8'hFF, 1'b1, 1'b0, '0, 1'b0),
                      tok(8'h01, 1'b0, 1'b0, '0, 1'b0),
                      tok(CH_NUL, 1'b0, 1'b1, 16'd1, 1'b1)));
    add_row(in_row(CH_QUOTE, 1'b1, 1'b0));
    add_row(in_row(CH_LANGLE, 1'b1, 1'b0));
    add_row(in_row(letter(0, 1'b1), 1'b1, 1'b0));
    add_row(in_row(CH_DOT, 1'b1, 1'b0));
    add_row(in_row(letter(1, 1'b1), 1'b1, 1'b0));
    add_row(in_row(CH_RANGLE, 1'b1, 1'b0));
    add_row(in_row(CH_BANG, 1'b1, 1'b0));
    add_row(in_row(CH_SPACE, 1'b1, 1'b0));
    add_row(in_row(CH_LBRACE, 1'b1, 1'b0));
    add_row(in_row(letter(16, 1'b0), 1'b1, 1'b0));
    add_row(in_row(CH_RBRACE, 1'b1, 1'b0));
    add_row(in_row(CH_COMMA, 1'b1, 1'b1));
    add_row(cfg_row(REG_FOLD_LOWER, 8'd1));
    add_row(cfg_row(REG_SPLIT_ON_SEP, 8'd1));
    add_row(cfg_row(REG_SEPARATOR, letter(1, 1'b0)));
    add_row(in_row(CH_NL, 1'b1, 1'b0));
    add_row(in_row(letter(0, 1'b0), 1'b1, 1'b0));
    add_row(in_row(CH_LPAREN, 1'b1, 1'b0));
    add_row(in_row(letter(1, 1'b0), 1'b1, 1'b0));
    add_row(in_row(CH_RPAREN, 1'b1, 1'b0));
    add_row(in_row(CH_HYPHEN, 1'b1, 1'b0));
    add_row(in_row(CH_COLON, 1'b1, 1'b0));
    add_row(in_row(CH_LSQUARE, 1'b1, 1'b0));
    add_row(in_row(CH_SEMI, 1'b1, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_cfg(dir_rows[i].reg_idx, dir_rows[i].ch);
      end else begin
        send_row(dir_rows[i]);
      end
    end

    run_phase(1'b1, 1'b0, CH_NUL, 28, 82, 1'b0);
    run_phase(1'b1, 1'b1, CH_UPPER_A, 28, 82, 1'b0);
    run_phase(1'b0, 1'b1, CH_NUL, 82, 28, 1'b0);
    run_phase(1'b0, 1'b0, 8'hFF, 82, 28, 1'b0);
    run_phase(1'b0, 1'b1, CH_COMMA, 0, 0, 1'b1);
    nest_deep();
    run_phase(1'b1, 1'b1, 8'hFF, 0, 0, 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
